// ===== hw/rtl/lock_command_frame_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// lock_command_frame_parser_unit_macros.svh
// Assertion helper macros for the lock command frame parser.
// ----------------------------------------------------------------------------
`ifndef LOCK_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define LOCK_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define LCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define LCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and constants of the lock command frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

    // frame bytes
    localparam logic [7:0] SYNC_BYTE = 8'h68;
    localparam logic [7:0] END_BYTE  = 8'h16;
    localparam logic [7:0] FC_UNLOCK = 8'h01;
    localparam logic [7:0] FC_LOCK   = 8'h02;
    localparam logic [7:0] LEN_MIN   = 8'd9;

    // defaults
    localparam int MAX_FRAME_DEF   = 128;
    localparam int QUEUE_DEPTH_DEF = 2;

    // frame status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_ACCEPT   = 3'd1;
    localparam logic [2:0] ST_BAD_HDR  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_BAD_END  = 3'd4;
    localparam logic [2:0] ST_BAD_SUM  = 3'd5;

    // lock actions handed from front to back
    localparam logic [1:0] LOCK_KEEP = 2'd0;
    localparam logic [1:0] LOCK_SET  = 2'd1;
    localparam logic [1:0] LOCK_CLR  = 2'd2;

    // classified word, one per received byte
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] func;
        logic [7:0] len;
        logic [1:0] lock_cmd;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    localparam int ITEM_W = $bits(t_item);
    localparam int OUT_W  = 24;

endpackage

// ===== hw/rtl/lock_command_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// lock_command_frame_parser_unit
// Parses 0x68-framed lock command frames and drives the lock output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries received bytes, one byte per word.
//   Master stream (o_m_*) returns exactly one result word per byte: frame
//   status, function code, declared length and the lock level after it.
//   Bytes outside a frame are dropped with status busy; a frame ends with
//   accept, header mismatch, bad length (judged after byte 8), bad end or
//   bad sum, and the parser goes back to hunting for 0x68.
//   Path: the result of a byte goes from the tracker step into the queue,
//   then into the output register.
//   Throughput: one byte per cycle while o_s_tready is high; the tracker
//   state update is the loop that sets this.
//   Reset (i_rst_n low, synchronous): hunting, queue empty, no result
//   pending, lock level 0 (locked).
//   Receiver stall: the output word holds; the two-entry queue absorbs up
//   to two more bytes, then o_s_tready drops until the receiver drains it.
// ----------------------------------------------------------------------------
module lock_command_frame_parser_unit import lcfp_pkg::*; #(
    parameter int MAX_FRAME   = MAX_FRAME_DEF,    // 9..255
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // power of two
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [2:0] frame_status, [10:3] func_code, [18:11] frame_len,
    // [19] lock_drive, [23:20] zero
    output logic [OUT_W-1:0] o_m_tdata
);

    t_item     front_item;
    t_item     q_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // front: frame tracking, one classified word per byte
    lcfp_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (front_item)
    );

    // decoupling queue
    lcfp_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_item),
        .i_pop    (pop),
        .o_data   (q_item),
        .o_status (q_status)
    );

    // back: lock level and output register
    lcfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata)
    );

endmodule

// ===== hw/rtl/lcfp_front.sv =====
// ----------------------------------------------------------------------------
// lcfp_front
// Byte tracker: frame hunting, header checks, checksum, status per byte.
// ----------------------------------------------------------------------------
module lcfp_front import lcfp_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_item      o_item
);

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME);

    localparam logic [1:0] HDR_NONE     = 2'd0;
    localparam logic [1:0] HDR_BAD_SYNC = 2'd1;
    localparam logic [1:0] HDR_LEN_DIFF = 2'd2;

    localparam logic [7:0] POS_LEN1  = 8'd1;
    localparam logic [7:0] POS_LEN2  = 8'd2;
    localparam logic [7:0] POS_SYNC2 = 8'd3;
    localparam logic [7:0] POS_FUNC  = 8'd4;
    localparam logic [7:0] POS_JUDGE = 8'd8;

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_pos,      n_pos;
    logic [7:0] r_len,      n_len;
    logic [1:0] r_fault,    n_fault;
    logic [7:0] r_sum,      n_sum;
    logic       r_sum_ok,   n_sum_ok;
    logic [7:0] r_func,     n_func;

    logic [8:0] pos_p1, pos_p2;
    logic [2:0] status;
    logic [1:0] cmd;
    logic       done;
    logic       take;

    assign o_ready = !i_q_status.full;
    assign take    = i_valid && o_ready;
    assign pos_p1  = {1'b0, r_pos} + 9'd1;
    assign pos_p2  = {1'b0, r_pos} + 9'd2;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_len      = r_len;
        n_fault    = r_fault;
        n_sum      = r_sum;
        n_sum_ok   = r_sum_ok;
        n_func     = r_func;
        status     = ST_BUSY;
        cmd        = LOCK_KEEP;
        done       = 1'b0;
        if (!r_in_frame) begin
            if (i_byte == SYNC_BYTE) begin
                n_in_frame = 1'b1;
                n_pos      = POS_LEN1;
                n_sum      = SYNC_BYTE;
                n_len      = 8'd0;
                n_fault    = HDR_NONE;
                n_sum_ok   = 1'b0;
                n_func     = 8'd0;
            end
        end else begin
            if (r_pos == POS_LEN1) n_len = i_byte;
            if (r_pos == POS_LEN2 && i_byte != r_len) n_fault = HDR_LEN_DIFF;
            if (r_pos == POS_SYNC2 && i_byte != SYNC_BYTE) n_fault = HDR_BAD_SYNC;
            if (r_pos == POS_FUNC) n_func = i_byte;

            // sum covers bytes up to len-3, byte len-2 is the checksum
            if (pos_p2 < {1'b0, n_len}) begin
                n_sum = r_sum + i_byte;
            end else if (pos_p2 == {1'b0, n_len}) begin
                n_sum_ok = (i_byte == r_sum);
            end

            if (r_pos == POS_JUDGE) begin
                if (n_fault == HDR_BAD_SYNC) begin
                    status = ST_BAD_HDR;
                    done   = 1'b1;
                end else if (n_fault == HDR_LEN_DIFF || n_len < LEN_MIN ||
                             n_len > MaxLen) begin
                    status = ST_BAD_LEN;
                    done   = 1'b1;
                end
            end

            // last byte; with a nine-byte frame this is the judge byte too
            if (!done && r_pos >= POS_JUDGE && pos_p1 == {1'b0, n_len}) begin
                if (i_byte != END_BYTE) begin
                    status = ST_BAD_END;
                end else if (!n_sum_ok) begin
                    status = ST_BAD_SUM;
                end else begin
                    status = ST_ACCEPT;
                    if (n_func == FC_UNLOCK) begin
                        cmd = LOCK_SET;
                    end else if (n_func == FC_LOCK) begin
                        cmd = LOCK_CLR;
                    end
                end
                done = 1'b1;
            end

            if (done) begin
                n_in_frame = 1'b0;
                n_pos      = 8'd0;
            end else begin
                n_pos = pos_p1[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 8'd0;
            r_len      <= 8'd0;
            r_fault    <= HDR_NONE;
            r_sum      <= 8'd0;
            r_sum_ok   <= 1'b0;
            r_func     <= 8'd0;
        end else if (take) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_fault    <= n_fault;
            r_sum      <= n_sum;
            r_sum_ok   <= n_sum_ok;
            r_func     <= n_func;
        end
    end

    assign o_push          = take;
    assign o_item.status   = status;
    assign o_item.func     = n_func;
    assign o_item.len      = n_len;
    assign o_item.lock_cmd = cmd;

endmodule

// ===== hw/rtl/lcfp_queue.sv =====
// ----------------------------------------------------------------------------
// lcfp_queue
// Small synchronous FIFO between the byte tracker and the output side.
// ----------------------------------------------------------------------------
module lcfp_queue import lcfp_pkg::*; #(
    parameter int WIDTH = ITEM_W,
    parameter int DEPTH = QUEUE_DEPTH_DEF   // power of two, at least 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_status.empty = (r_count == CW'(0));
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + AW'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== hw/rtl/lcfp_back.sv =====
// ----------------------------------------------------------------------------
// lcfp_back
// Lock level keeper and registered result word.
// ----------------------------------------------------------------------------
module lcfp_back import lcfp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data
);

    logic             r_lock,  n_lock;
    logic             r_valid;
    logic [OUT_W-1:0] r_data;
    logic             pop;

    assign pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign o_pop = pop;

    always_comb begin
        case (i_item.lock_cmd)
            LOCK_SET: n_lock = 1'b1;
            LOCK_CLR: n_lock = 1'b0;
            default:  n_lock = r_lock;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_lock  <= n_lock;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // pad, lock, len, func, status from the top bit down
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_data <= {4'd0, n_lock, i_item.len, i_item.func, i_item.status};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/lcfp_checker.sv =====
// ----------------------------------------------------------------------------
// lcfp_checker
// Port-level checks of the lock command frame parser, bound to the top.
// ----------------------------------------------------------------------------
`include "lock_command_frame_parser_unit_macros.svh"

module lcfp_checker import lcfp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    `LCFP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "word changed while stalled")

    `LCFP_ASSERT_NOW(a_status_range, o_m_tvalid, o_m_tdata[2:0] <= ST_BAD_SUM,
        "frame status out of range")

    `LCFP_ASSERT_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[23:20] == 4'd0,
        "pad bits not zero")

    `LCFP_ASSERT_NOW(a_accept_len, o_m_tvalid && o_m_tdata[2:0] == ST_ACCEPT,
        o_m_tdata[18:11] >= LEN_MIN, "accepted frame shorter than minimum")

    // with no word pending at the output the queue cannot be full
    `LCFP_ASSERT_NOW(a_in_ready_idle, !o_m_tvalid, o_s_tready,
        "input stalled with output idle")

endmodule

bind lock_command_frame_parser_unit lcfp_checker u_lcfp_checker (.*);
